FILE: sv/salc_pkg.sv
// Shared types and constants for the set-associative LRU cache simulator.
`timescale 1ns / 1ps
package salc_pkg;
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_STORE  = 2'd1;
   localparam logic [1:0] OP_MODIFY = 2'd2;

   localparam logic [1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [1:0] CSR_BLOCK_BITS = 2'd1;
   localparam logic [1:0] CSR_WAYS       = 2'd2;

   localparam int TAG_W   = 62;
   localparam int STAMP_W = 32;
   localparam int SUM_W   = 32;

   // Controller to datapath
   typedef struct packed {
      logic clear;     // write an invalid line into every way of one set
      logic capture;   // latch request, start set read
      logic lookup;    // compare ways, update line and totals
   } salc_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_done;
      logic valid_op;
   } salc_sts_type;
endpackage

FILE: sv/set_assoc_lru_cache_sim_core.sv
// Top level of the set-associative LRU cache simulator.
// Each access has a capture step that reads all ways of the set from the per-way
// valid/tag/stamp RAMs and a lookup step that compares, picks the victim and
// writes back; a new access is taken after the previous lookup, while the result
// slot can drain. After reset one set per cycle is invalidated, 2^MAX_SET_BITS
// sets in all (64 by default), before the first request is accepted.
`timescale 1ns / 1ps
module set_assoc_lru_cache_sim_core import salc_pkg::*; #(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [71:0]   req_tdata,   // op[1:0], address[65:2], zero fill
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [5:0]    csr_data,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [103:0]  rsp_tdata    // hits_added[1:0], was_miss[2],
                                      // was_eviction[3], hit_sum[35:4],
                                      // miss_sum[67:36], eviction_sum[99:68]
);
   logic [2:0] set_bits_ff;
   logic [5:0] block_bits_ff;
   logic [3:0] ways_ff;
   salc_cmd_type cmd;
   salc_sts_type sts;
   logic [1:0] hits;
   logic miss, evict;
   logic [SUM_W-1:0] hs, ms, es;

   assign csr_ready = 1'b1;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= 3'd1;
         block_bits_ff <= 6'd1;
         ways_ff       <= 4'd1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SET_BITS:   set_bits_ff   <= csr_data[2:0];
            CSR_BLOCK_BITS: block_bits_ff <= csr_data;
            CSR_WAYS:       ways_ff       <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   salc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .sts(sts), .cmd(cmd));

   salc_dp #(.MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .op(req_tdata[1:0]), .address(req_tdata[65:2]),
      .set_bits(set_bits_ff), .block_bits(block_bits_ff), .ways_in_use(ways_ff),
      .hits_added(hits), .was_miss(miss), .was_eviction(evict),
      .hit_sum(hs), .miss_sum(ms), .eviction_sum(es));

   assign rsp_tdata = {4'd0, es, ms, hs, evict, miss, hits};

   // An eviction is always also a miss
   a_evict_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3] |-> rsp_tdata[2]) else $error("eviction without miss");
   // A result follows every lookup cycle
   a_lookup_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.lookup |=> rsp_tvalid) else $error("lookup without result");
   // An invalid op adds no hits and flags no miss or eviction
   a_bad_op: assert property (@(posedge clock) disable iff (reset)
      cmd.lookup && !sts.valid_op |=> rsp_tdata[3:0] == 4'd0) else $error("op 3 counted");
endmodule

FILE: sv/salc_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`timescale 1ns / 1ps
module salc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: sv/salc_ctrl.sv
// Controller state machine for the cache simulator.
`timescale 1ns / 1ps
module salc_ctrl import salc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  salc_sts_type sts,
   output salc_cmd_type cmd
);
   localparam logic [1:0] IDLE  = 2'd0;
   localparam logic [1:0] LOOK  = 2'd1;
   localparam logic [1:0] CLEAR = 2'd2;

   logic [1:0] state_ff, state_in;
   logic rv_ff, rv_in;

   // Accept a new request in IDLE when the result slot will be free
   assign req_tready = (state_ff == IDLE) && (!rv_ff || rsp_tready);
   assign cmd.capture = req_tvalid && req_tready;
   assign cmd.lookup  = (state_ff == LOOK);
   assign cmd.clear   = (state_ff == CLEAR);
   assign rsp_tvalid  = rv_ff;

   always_comb begin
      state_in = state_ff;
      rv_in    = rv_ff;
      if (rv_ff && rsp_tready) rv_in = 1'b0;
      unique case (state_ff)
         IDLE: if (cmd.capture) state_in = LOOK;
         LOOK: begin
            state_in = IDLE;
            rv_in    = 1'b1;
         end
         CLEAR: if (sts.clear_done) state_in = IDLE;
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CLEAR;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
      end
   end
endmodule

FILE: sv/salc_dp.sv
// Datapath: address split, way compare, LRU victim pick, line and total update.
`timescale 1ns / 1ps
module salc_dp import salc_pkg::*; #(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  salc_cmd_type       cmd,
   output salc_sts_type       sts,
   input  logic [1:0]         op,
   input  logic [63:0]        address,
   input  logic [2:0]         set_bits,
   input  logic [5:0]         block_bits,
   input  logic [3:0]         ways_in_use,
   output logic [1:0]         hits_added,
   output logic               was_miss,
   output logic               was_eviction,
   output logic [SUM_W-1:0]   hit_sum,
   output logic [SUM_W-1:0]   miss_sum,
   output logic [SUM_W-1:0]   eviction_sum
);
   localparam int NSETS = 1 << MAX_SET_BITS;
   localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WCNT_W = $clog2(MAX_WAYS + 1);
   localparam int LINE_W = 1 + TAG_W + STAMP_W;
   localparam int SB_W = $clog2(MAX_SET_BITS + 1);

   logic [1:0]              op_ff;
   logic [TAG_W-1:0]        tag_ff;
   logic [MAX_SET_BITS-1:0] set_ff;
   logic [WCNT_W-1:0]       ways_ff;
   logic [STAMP_W-1:0]      ctr_ff;
   logic [SUM_W-1:0]        hsum_ff, msum_ff, esum_ff;
   logic [MAX_SET_BITS-1:0] clr_ff;
   logic [MAX_SET_BITS-1:0] wr_set;
   logic [1:0]              hits_ff;
   logic                    miss_ff, evict_ff;

   // Address split
   logic [SB_W-1:0]         sb;
   logic [6:0]              sh;
   logic [63:0]             addr_sh, tag_sh;
   logic [MAX_SET_BITS-1:0] set_in;
   logic [WCNT_W-1:0]       ways_in;

   always_comb begin
      sb = (32'(set_bits) > MAX_SET_BITS) ? SB_W'(MAX_SET_BITS) : SB_W'(set_bits);
      sh = 7'(sb) + 7'(block_bits);
      addr_sh = address >> block_bits;
      set_in = addr_sh[MAX_SET_BITS-1:0] & MAX_SET_BITS'((64'd1 << sb) - 64'd1);
      tag_sh = (sh >= 7'd64) ? 64'd0 : (address >> sh);
      if (ways_in_use == 4'd0) ways_in = WCNT_W'(1);
      else if (32'(ways_in_use) > MAX_WAYS) ways_in = WCNT_W'(MAX_WAYS);
      else ways_in = WCNT_W'(ways_in_use);
   end

   // Step through the sets after reset, invalidating every way
   assign wr_set = cmd.clear ? clr_ff : set_ff;
   assign sts.clear_done = (clr_ff == '1);

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clear) clr_ff <= clr_ff + 1'b1;
   end

   // One RAM per way holds valid, tag and stamp
   logic [LINE_W-1:0] rd [MAX_WAYS];
   logic [MAX_WAYS-1:0] we;
   logic [LINE_W-1:0] wdata;

   for (genvar w = 0; w < MAX_WAYS; w++) begin : g_way
      salc_ram #(.WIDTH(LINE_W), .DEPTH(NSETS)) u_ram (
         .clock(clock), .wr_en(we[w]), .wr_addr(wr_set), .wr_data(wdata),
         .rd_addr(set_in), .rd_data(rd[w]));
   end

   // Compare, pick the hit way, else the first empty way, else the oldest way
   logic [MAX_WAYS-1:0] vld;
   logic                hit, empty;
   logic [WAY_W-1:0]    hit_w, emp_w, old_w, vic_w;
   logic [STAMP_W-1:0]  best;
   logic                do_op;

   assign do_op = (op_ff <= OP_MODIFY);
   assign sts.valid_op = do_op;

   always_comb begin
      hit = 1'b0; empty = 1'b0;
      hit_w = '0; emp_w = '0; old_w = '0;
      best = rd[0][STAMP_W-1:0];
      for (int w = 0; w < MAX_WAYS; w++) begin
         vld[w] = rd[w][LINE_W-1];
         if (WCNT_W'(w) < ways_ff) begin
            if (!hit && vld[w] && rd[w][TAG_W+STAMP_W-1:STAMP_W] == tag_ff) begin
               hit = 1'b1; hit_w = WAY_W'(w);
            end
            if (!empty && !vld[w]) begin
               empty = 1'b1; emp_w = WAY_W'(w);
            end
            if (w > 0 && rd[w][STAMP_W-1:0] < best) begin
               best = rd[w][STAMP_W-1:0]; old_w = WAY_W'(w);
            end
         end
      end
      vic_w = hit ? hit_w : (empty ? emp_w : old_w);
      wdata = cmd.clear ? '0 : {1'b1, tag_ff, ctr_ff};
      for (int w = 0; w < MAX_WAYS; w++)
         we[w] = cmd.clear || (cmd.lookup && do_op && (vic_w == WAY_W'(w)));
   end

   logic [1:0] h_in;
   logic m_in, e_in;
   assign h_in = !do_op ? 2'd0 : (hit ? ((op_ff == OP_MODIFY) ? 2'd2 : 2'd1)
                                      : ((op_ff == OP_MODIFY) ? 2'd1 : 2'd0));
   assign m_in = do_op && !hit;
   assign e_in = do_op && !hit && !empty;

   function automatic logic [SUM_W-1:0] sat(input logic [SUM_W-1:0] a,
                                            input logic [1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + (SUM_W+1)'(b);
      return s[SUM_W] ? '1 : s[SUM_W-1:0];
   endfunction

   // Capture request, then update on lookup
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= op;
         tag_ff  <= tag_sh[TAG_W-1:0];
         set_ff  <= set_in;
         ways_ff <= ways_in;
      end
      if (cmd.lookup) begin
         hits_ff  <= h_in;
         miss_ff  <= m_in;
         evict_ff <= e_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctr_ff   <= 32'd1;
         hsum_ff  <= '0;
         msum_ff  <= '0;
         esum_ff  <= '0;
      end else if (cmd.lookup && do_op) begin
         ctr_ff  <= ctr_ff + 32'd1;
         hsum_ff <= sat(hsum_ff, h_in);
         msum_ff <= sat(msum_ff, {1'b0, m_in});
         esum_ff <= sat(esum_ff, {1'b0, e_in});
      end
   end

   assign hits_added   = hits_ff;
   assign was_miss     = miss_ff;
   assign was_eviction = evict_ff;
   assign hit_sum      = hsum_ff;
   assign miss_sum     = msum_ff;
   assign eviction_sum = esum_ff;
endmodule

FILE: verif/set_assoc_lru_cache_sim_core_checker.sv
// Checker for the cache simulator: predicts each access result and compares it.
`timescale 1ns / 1ps
module set_assoc_lru_cache_sim_core_checker import salc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_tready,
   input  logic [71:0]   req_tdata,
   input  logic          csr_valid,
   input  logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [5:0]    csr_data,
   input  logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic [103:0]  rsp_tdata,
   output int            fail_count,
   output int            pending_count,
   output int            rsp_count
);
   localparam int NUM_SETS = 64;
   localparam int NUM_LINES = NUM_SETS * 8;
   localparam int MAX_SET_BITS_C = 6;

   typedef struct packed {
      logic [31:0] eviction_sum;
      logic [31:0] miss_sum;
      logic [31:0] hit_sum;
      logic        was_eviction;
      logic        was_miss;
      logic [1:0]  hits_added;
   } access_result_type;

   logic [TAG_W-1:0]   tag_mem [NUM_LINES];
   logic               valid_mem [NUM_LINES];
   logic [STAMP_W-1:0] stamp_mem [NUM_LINES];
   logic [31:0] stamp_clock, hit_acc, miss_acc, evict_acc;
   logic [2:0]  cfg_set_bits;
   logic [5:0]  cfg_block_bits;
   logic [3:0]  cfg_ways;
   access_result_type expected_results [$];

   function automatic logic [31:0] sat_inc(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   // Apply one access to the shadow cache and return its result
   function automatic access_result_type predict_access(logic [1:0] op, logic [63:0] addr);
      access_result_type r;
      int sb, ways, set_idx, base, found, victim, shift;
      logic [63:0] shifted;
      logic [TAG_W-1:0] tag;
      logic [31:0] best;
      logic empty;
      r = '0;
      if (op != OP_LOAD && op != OP_STORE && op != OP_MODIFY) begin
         r.hit_sum = hit_acc; r.miss_sum = miss_acc; r.eviction_sum = evict_acc;
         return r;
      end
      sb = (cfg_set_bits > MAX_SET_BITS_C) ? MAX_SET_BITS_C : cfg_set_bits;
      ways = (cfg_ways == 0) ? 1 : ((cfg_ways > 8) ? 8 : cfg_ways);
      shifted = addr >> cfg_block_bits;
      set_idx = int'(shifted & ((64'd1 << sb) - 1));
      shift = sb + cfg_block_bits;
      tag = (shift >= 64) ? '0 : TAG_W'(addr >> shift);
      base = set_idx * 8;
      found = -1;
      for (int w = 0; w < ways; w++)
         if (found < 0 && valid_mem[base+w] && tag_mem[base+w] == tag) found = w;
      if (found >= 0) begin
         stamp_mem[base+found] = stamp_clock;
         r.hits_added = (op == OP_MODIFY) ? 2'd2 : 2'd1;
      end else begin
         r.was_miss = 1'b1;
         victim = 0; empty = 1'b0;
         for (int w = 0; w < ways; w++)
            if (!empty && !valid_mem[base+w]) begin victim = w; empty = 1'b1; end
         if (!empty) begin
            best = stamp_mem[base];
            for (int w = 1; w < ways; w++)
               if (stamp_mem[base+w] < best) begin best = stamp_mem[base+w]; victim = w; end
            r.was_eviction = 1'b1;
         end
         tag_mem[base+victim] = tag;
         valid_mem[base+victim] = 1'b1;
         stamp_mem[base+victim] = stamp_clock;
         if (op == OP_MODIFY) r.hits_added = 2'd1;
      end
      stamp_clock = stamp_clock + 1;
      hit_acc = sat_inc(hit_acc, 32'(r.hits_added));
      miss_acc = sat_inc(miss_acc, 32'(r.was_miss));
      evict_acc = sat_inc(evict_acc, 32'(r.was_eviction));
      r.hit_sum = hit_acc; r.miss_sum = miss_acc; r.eviction_sum = evict_acc;
      return r;
   endfunction

   assign pending_count = expected_results.size();

   // Track configuration, predict on requests, compare on responses
   always @(posedge clock) begin
      access_result_type exp_r, act_r;
      if (reset) begin
         for (int i = 0; i < NUM_LINES; i++) begin
            valid_mem[i] = 1'b0; stamp_mem[i] = '0; tag_mem[i] = '0;
         end
         stamp_clock = 1; hit_acc = 0; miss_acc = 0; evict_acc = 0;
         cfg_set_bits = 3'd1; cfg_block_bits = 6'd1; cfg_ways = 4'd1;
         expected_results.delete();
         fail_count <= 0;
         rsp_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SET_BITS:   cfg_set_bits = csr_data[2:0];
               CSR_BLOCK_BITS: cfg_block_bits = csr_data;
               CSR_WAYS:       cfg_ways = csr_data[3:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(predict_access(req_tdata[1:0], req_tdata[65:2]));
         if (rsp_tvalid && rsp_tready) begin
            act_r = access_result_type'(rsp_tdata[99:0]);
            rsp_count <= rsp_count + 1;
            if (expected_results.size() == 0) begin
               $error("unexpected result transaction %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               exp_r = expected_results.pop_front();
               if (exp_r != act_r) begin
                  if (exp_r.hits_added != act_r.hits_added)
                     $error("hits_added expected %0d actual %0d", exp_r.hits_added,
                            act_r.hits_added);
                  if (exp_r.was_miss != act_r.was_miss)
                     $error("was_miss expected %0d actual %0d", exp_r.was_miss,
                            act_r.was_miss);
                  if (exp_r.was_eviction != act_r.was_eviction)
                     $error("was_eviction expected %0d actual %0d", exp_r.was_eviction,
                            act_r.was_eviction);
                  if (exp_r.hit_sum != act_r.hit_sum)
                     $error("hit_sum expected %0d actual %0d", exp_r.hit_sum, act_r.hit_sum);
                  if (exp_r.miss_sum != act_r.miss_sum)
                     $error("miss_sum expected %0d actual %0d", exp_r.miss_sum,
                            act_r.miss_sum);
                  if (exp_r.eviction_sum != act_r.eviction_sum)
                     $error("eviction_sum expected %0d actual %0d", exp_r.eviction_sum,
                            act_r.eviction_sum);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

FILE: verif/set_assoc_lru_cache_sim_core_tb.sv
// Top of the cache simulator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module set_assoc_lru_cache_sim_core_tb;
   import salc_pkg::*;

   localparam int LIMIT = 400000;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [71:0]   req_tdata = '0;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [1:0]    csr_index = CSR_SET_BITS;
   logic [5:0]    csr_data = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [103:0]  rsp_tdata;
   int            fail_count, pending_count, rsp_count;
   int            cycle_count = 0;
   int            access_count = 0;
   int            phase_count = 0;
   logic          stall_enable = 1'b1;
   logic [63:0]   addr_pool [8];

   always #2 clock = ~clock;

   set_assoc_lru_cache_sim_core DUT (.*);

   set_assoc_lru_cache_sim_core_checker checker_inst (.*);

   // Stall the receiver on its own pattern
   always @(posedge clock) begin
      if (!stall_enable) rsp_tready <= 1'b1;
      else case (cycle_count[9:8])
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= ($urandom_range(3) != 0);
         2'd2: rsp_tready <= ($urandom_range(1) == 0);
         default: rsp_tready <= ($urandom_range(7) == 0);
      endcase
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [5:0] val);
      csr_valid <= 1'b1; csr_index <= idx; csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Stop sending and wait until every result is back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(logic [5:0] sb, logic [5:0] bb, logic [5:0] ways);
      drain_results();
      write_reg(CSR_SET_BITS, sb);
      write_reg(CSR_BLOCK_BITS, bb);
      write_reg(CSR_WAYS, ways);
      phase_count++;
   endtask

   // Hold one access until the block takes it; an optional gap follows
   task automatic send_access(logic [1:0] op, logic [63:0] addr, int gap);
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, addr, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      access_count++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Random accesses clustered on a few lines so sets fill, hit and evict
   task automatic random_phase(int n, logic [5:0] bb);
      int burst;
      logic [1:0] op;
      logic [63:0] a;
      for (int i = 0; i < 8; i++) addr_pool[i] = {$urandom, $urandom};
      burst = 0;
      for (int i = 0; i < n; i++) begin
         op = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
         if ($urandom_range(9) < 8) begin
            a = addr_pool[$urandom_range(7)];
            a[7:0] = a[7:0] ^ 8'($urandom_range(7) << bb);
            a = a ^ (64'($urandom_range(3)) << (bb + 6));
         end else a = {$urandom, $urandom};
         if (burst == 0) burst = $urandom_range(1, 12);
         burst--;
         send_access(op, a, (burst == 0) ? $urandom_range(0, 6) : 0);
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: default setup, every op, unused op, hit, miss and eviction
      send_access(OP_LOAD, 64'd0, 0);
      send_access(OP_STORE, 64'd0, 0);
      send_access(OP_MODIFY, 64'd0, 0);
      send_access(2'd3, 64'd0, 0);
      send_access(OP_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF, 0);
      send_access(OP_LOAD, 64'h8000_0000_0000_0000, 0);
      send_access(OP_LOAD, 64'h0000_0000_0000_0004, 1);
      req_tvalid <= 1'b0;
      // Tiny shift: top address bits fall outside the kept tag
      configure(6'd0, 6'd1, 6'd0);
      send_access(OP_LOAD, 64'h4000_0000_0000_0000, 0);
      send_access(OP_LOAD, 64'hC000_0000_0000_0000, 0);
      // Out-of-range values saturate; wide shift gives a zero tag
      configure(6'd7, 6'd63, 6'd15);
      send_access(OP_LOAD, 64'h1234_5678_9ABC_DEF0, 0);
      send_access(OP_STORE, 64'hFFFF_0000_0000_0000, 0);
      configure(6'd6, 6'd56, 6'd8);
      for (int i = 0; i < 10; i++) send_access(OP_LOAD, 64'(i) << 62, 0);
      req_tvalid <= 1'b0;

      // Let everything drain once before the random part
      drain_results();

      configure(6'd1, 6'd1, 6'd1);  random_phase(150, 6'd1);
      configure(6'd6, 6'd4, 6'd8);  random_phase(200, 6'd4);
      configure(6'd2, 6'd3, 6'd4);  random_phase(200, 6'd3);
      stall_enable <= 1'b0;
      configure(6'd3, 6'd6, 6'd2);  random_phase(150, 6'd6);
      stall_enable <= 1'b1;
      configure(6'd1, 6'd56, 6'd8); random_phase(100, 6'd56);
      configure(6'd4, 6'd2, 6'd3);  random_phase(150, 6'd2);
      configure(6'd6, 6'd1, 6'd5);  random_phase(150, 6'd1);

      drain_results();
      repeat (20) @(posedge clock);
      $display("Covered %0d accesses over %0d register settings, %0d results checked.",
               access_count, phase_count, rsp_count);
      if (fail_count == 0 && pending_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule

FILE: set_assoc_lru_cache_sim_core.f
sv/salc_pkg.sv
sv/salc_ram.sv
sv/salc_ctrl.sv
sv/salc_dp.sv
sv/set_assoc_lru_cache_sim_core.sv
verif/set_assoc_lru_cache_sim_core_checker.sv
verif/set_assoc_lru_cache_sim_core_tb.sv
